>>> hw/rtl/tfrl_pkg.sv
// Shared types and constants for the throttle filter / ramp level unit.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package tfrl_pkg;

	// Fixed widths of the register fields and the result level
	localparam int TH_W    = 12;	// assist_start / regen_start
	localparam int LVL_W   = 7;	// max_assist / max_regen, also quotient bits
	localparam int OUT_W   = 8;	// signed drive level
	localparam int BIT_W   = $clog2(LVL_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = TH_W;

	// Default parameter values
	localparam int FILTER_SHIFT_DEF = 5;
	localparam int SAMPLE_BITS_DEF  = 12;
	localparam int HISTORY_BITS_DEF = 8;

	// Register reset values
	localparam logic [TH_W-1:0]  ASSIST_START_RST = 12'd2300;
	localparam logic [TH_W-1:0]  REGEN_START_RST  = 12'd1800;
	localparam logic [LVL_W-1:0] MAX_ASSIST_RST   = 7'd20;
	localparam logic [LVL_W-1:0] MAX_REGEN_RST    = 7'd30;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ASSIST_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGEN_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ASSIST   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REGEN    = 2'd3;

	// Controller to datapath
	typedef struct packed {
		logic             load;	// accept word: update filter and history
		logic             mul_go;	// pick deadband side, multiply, load divider
		logic             div_step;	// one restoring division step
		logic [BIT_W-1:0] div_bit;	// quotient bit of this step
		logic             finish;	// update level, load output register
	} tfrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;	// output register holds a word not taken this cycle
	} tfrl_sts_t;

endpackage

>>> hw/rtl/tfrl_div.sv
// Restoring divider, one quotient bit per step, most significant bit first.
// Depends on tfrl_pkg for the quotient width.
`timescale 1ns / 1ps

module tfrl_div #(
	parameter int DEN_W = 13,
	parameter int NUM_W = 20
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic [NUM_W-1:0]            dividend,
	input  logic [DEN_W-1:0]            divisor,
	input  logic                        step,
	input  logic [tfrl_pkg::BIT_W-1:0]  step_bit,
	output logic [tfrl_pkg::LVL_W-1:0]  quotient
);

	logic [NUM_W-1:0]           rem_q;
	logic [DEN_W-1:0]           den_q;
	logic [tfrl_pkg::LVL_W-1:0] quo_q;
	logic [NUM_W-1:0]           trial;

	// The caller guarantees dividend < divisor << LVL_W, so LVL_W steps suffice
	assign trial = NUM_W'(den_q) << step_bit;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= dividend;
			den_q <= divisor;
			quo_q <= '0;
		end else if (step) begin
			if (rem_q >= trial) begin
				rem_q           <= rem_q - trial;
				quo_q[step_bit] <= 1'b1;
			end
		end
	end

	assign quotient = quo_q;

endmodule

>>> hw/rtl/tfrl_dp.sv
// Datapath: config registers, leaky filter, switch history, deadband target,
// ramped level and output register. Depends on tfrl_pkg and tfrl_div.
`timescale 1ns / 1ps

module tfrl_dp #(
	parameter int FILTER_SHIFT = tfrl_pkg::FILTER_SHIFT_DEF,
	parameter int SAMPLE_BITS  = tfrl_pkg::SAMPLE_BITS_DEF,
	parameter int HISTORY_BITS = tfrl_pkg::HISTORY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tfrl_pkg::tfrl_cmd_t              cmd,
	output tfrl_pkg::tfrl_sts_t              sts,
	input  logic                             cfg_we,
	input  logic [tfrl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tfrl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [SAMPLE_BITS-1:0]           sample,
	input  logic                             switch_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [tfrl_pkg::OUT_W-1:0] drive_level,
	output logic [SAMPLE_BITS-1:0]           filtered_sample
);

	localparam int ACC_W = SAMPLE_BITS + FILTER_SHIFT;
	localparam int VAL_W = ((SAMPLE_BITS > tfrl_pkg::TH_W) ? SAMPLE_BITS : tfrl_pkg::TH_W) + 1;
	localparam int NUM_W = VAL_W + tfrl_pkg::LVL_W;

	logic [tfrl_pkg::TH_W-1:0]  assist_start_q, regen_start_q;
	logic [tfrl_pkg::LVL_W-1:0] max_assist_q, max_regen_q;

	logic [ACC_W-1:0]        acc_q, acc_base, acc_next;
	logic                    primed_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic signed [tfrl_pkg::OUT_W-1:0] lvl_q, target;
	logic                    neg_q;
	logic                    out_valid_q;
	logic signed [tfrl_pkg::OUT_W-1:0] out_lvl_q;
	logic [SAMPLE_BITS-1:0]  out_filt_q;

	logic [SAMPLE_BITS-1:0]     filt;
	logic [VAL_W-1:0]           f_ext, as_ext, rs_ext, span, diff, den;
	logic [tfrl_pkg::LVL_W-1:0] scale, quo;
	logic                       is_regen, is_assist;
	logic [NUM_W-1:0]           product;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assist_start_q <= tfrl_pkg::ASSIST_START_RST;
			regen_start_q  <= tfrl_pkg::REGEN_START_RST;
			max_assist_q   <= tfrl_pkg::MAX_ASSIST_RST;
			max_regen_q    <= tfrl_pkg::MAX_REGEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfrl_pkg::CFG_ASSIST_START: assist_start_q <= cfg_data;
				tfrl_pkg::CFG_REGEN_START:  regen_start_q  <= cfg_data;
				tfrl_pkg::CFG_MAX_ASSIST:   max_assist_q   <= cfg_data[tfrl_pkg::LVL_W-1:0];
				tfrl_pkg::CFG_MAX_REGEN:    max_regen_q    <= cfg_data[tfrl_pkg::LVL_W-1:0];
			endcase
		end
	end

	// Leaky integrator; the first word takes the bare sample as the previous accumulator value
	assign acc_base = primed_q ? acc_q : ACC_W'(sample);
	assign acc_next = acc_base - (acc_base >> FILTER_SHIFT) + ACC_W'(sample);
	assign filt     = acc_q[ACC_W-1:FILTER_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			primed_q <= 1'b0;
			hist_q   <= '0;
		end else if (cmd.load) begin
			acc_q    <= acc_next;
			primed_q <= 1'b1;
			hist_q   <= {hist_q[HISTORY_BITS-2:0], switch_in};
		end
	end

	// Deadband: regen wins when both sides apply; neither side gives a zero product
	assign f_ext     = VAL_W'(filt);
	assign as_ext    = VAL_W'(assist_start_q);
	assign rs_ext    = VAL_W'(regen_start_q);
	assign span      = (VAL_W'(1) << SAMPLE_BITS) - as_ext;
	assign is_regen  = f_ext < rs_ext;
	assign is_assist = f_ext > as_ext;

	always_comb begin
		if (is_regen) begin
			diff  = rs_ext - f_ext;
			scale = max_regen_q;
			den   = rs_ext;
		end else if (is_assist) begin
			diff  = f_ext - as_ext;
			scale = max_assist_q;
			den   = span;
		end else begin
			diff  = '0;
			scale = '0;
			den   = span;
		end
	end

	assign product = NUM_W'(diff) * NUM_W'(scale);

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			neg_q <= is_regen;
		end
	end

	tfrl_div #(
		.DEN_W(VAL_W),
		.NUM_W(NUM_W)
	) u_div (
		.clk      (clk),
		.load     (cmd.mul_go),
		.dividend (product),
		.divisor  (den),
		.step     (cmd.div_step),
		.step_bit (cmd.div_bit),
		.quotient (quo)
	);

	assign target = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	// Ramped level: clear on all-ones history; on all-zeros clear for a zero target, else step toward it; else hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (cmd.finish) begin
			if (&hist_q) begin
				lvl_q <= '0;
			end else if (hist_q == '0) begin
				if (target == '0) begin
					lvl_q <= '0;
				end else if (lvl_q < target) begin
					lvl_q <= lvl_q + 8'sd1;
				end else if (lvl_q > target) begin
					lvl_q <= lvl_q - 8'sd1;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_filt_q <= filt;
			if (&hist_q) begin
				out_lvl_q <= '0;
			end else if (hist_q == '0) begin
				if (target == '0) begin
					out_lvl_q <= '0;
				end else if (lvl_q < target) begin
					out_lvl_q <= lvl_q + 8'sd1;
				end else if (lvl_q > target) begin
					out_lvl_q <= lvl_q - 8'sd1;
				end else begin
					out_lvl_q <= lvl_q;
				end
			end else begin
				out_lvl_q <= lvl_q;
			end
		end
	end

	assign sts.out_busy   = out_valid_q & ~out_ready;
	assign out_valid      = out_valid_q;
	assign drive_level    = out_lvl_q;
	assign filtered_sample = out_filt_q;

endmodule

>>> hw/rtl/tfrl_ctrl.sv
// Controller: sequences accept, multiply, division steps and result load.
// Depends on tfrl_pkg for the command and status structs.
`timescale 1ns / 1ps

module tfrl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                tick,
	output logic                in_ready,
	input  tfrl_pkg::tfrl_sts_t sts,
	output tfrl_pkg::tfrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [tfrl_pkg::BIT_W-1:0] bit_q;
	logic                       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && tick) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
					bit_q   <= tfrl_pkg::BIT_W'(tfrl_pkg::LVL_W - 1);
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						bit_q <= bit_q - tfrl_pkg::BIT_W'(1);
					end
				end
				ST_DONE: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		cmd.load     = accept;
		cmd.mul_go   = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.div_bit  = bit_q;
		cmd.finish   = (state_q == ST_DONE) && !sts.out_busy;
	end

endmodule

>>> hw/rtl/throttle_filter_ramp_level_unit.sv
// Top level of the throttle filter / ramp level unit.
// Depends on tfrl_pkg, tfrl_ctrl, tfrl_dp (and tfrl_div below it).
`timescale 1ns / 1ps

// Each input word carries a throttle sample, a raw switch bit and a tick flag.
// A word without tick is taken while the unit is idle and leaves it idle: it advances the leaky filter and
// the switch history and yields nothing. A tick word goes through these steps from
// acceptance until its result is loaded into the output register: accept it,
// multiply the deadband distance by the configured maximum, run seven
// restoring division steps (one quotient bit each, set by the 7-bit level
// range) and update the ramped level. The unit takes the next
// word as soon as the result is loaded, even if that result still waits on
// out_ready; a later tick word then waits in its final cycle until the
// output register is free. Configuration writes are accepted at any time
// (cfg_ready is always high) but belong in idle periods.

module throttle_filter_ramp_level_unit #(
	parameter int FILTER_SHIFT = tfrl_pkg::FILTER_SHIFT_DEF,
	parameter int SAMPLE_BITS  = tfrl_pkg::SAMPLE_BITS_DEF,
	parameter int HISTORY_BITS = tfrl_pkg::HISTORY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input words
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic                              switch_in,
	input  logic                              tick,
	// result words
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tfrl_pkg::OUT_W-1:0] drive_level,
	output logic [SAMPLE_BITS-1:0]            filtered_sample,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tfrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tfrl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tfrl_pkg::tfrl_cmd_t cmd;
	tfrl_pkg::tfrl_sts_t sts;

	// Registers never stall a write
	assign cfg_ready = 1'b1;

	tfrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.tick     (tick),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tfrl_dp #(
		.FILTER_SHIFT (FILTER_SHIFT),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.HISTORY_BITS (HISTORY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample          (sample),
		.switch_in       (switch_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.drive_level     (drive_level),
		.filtered_sample (filtered_sample)
	);

endmodule
